// ===== sv/mecanum_odometry_velocity_top_defines.svh =====
// Assertion macros shared by the checker of the odometry block.
// Needs nothing else; include by bare file name.
`ifndef MECANUM_ODOMETRY_VELOCITY_TOP_DEFINES_SVH
`define MECANUM_ODOMETRY_VELOCITY_TOP_DEFINES_SVH

// same-cycle implication
`define MOV_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MOV_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mov_pkg.sv =====
// Shared constants, register codes and rounding helpers for the mecanum odometry block.
// No dependencies.
`default_nettype none

package mov_pkg;

  localparam int unsigned TRIG_TABLE_BITS_DEF = 10;
  localparam int unsigned TURN_BITS    = 19;
  localparam int unsigned QUAD_BITS    = 17;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned CNT_W        = 4;
  localparam int unsigned TRIG_W       = 20;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam logic [16:0] HEADING_TURN  = 17'd23040;
  localparam logic [16:0] HEADING_BIAS  = 17'd46080;
  localparam logic [14:0] HEADING_HALF  = 15'd11520;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 20'sd39797;

  // 23040 = 45 << 9; divide by 45 with ceil(2^26 / 45), exact below 2^20
  localparam int unsigned TURN_POW2_SHIFT = 9;
  localparam int unsigned RECIP_SHIFT     = 26;
  localparam logic [20:0] RECIP_45        = 21'd1491309;

  localparam logic [CFG_IDX_W-1:0] REG_GLITCH_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_X       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_YAW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_GATE     = 3'd4;

  localparam logic [14:0] GLITCH_LIMIT_RST = 15'd11520;
  localparam logic [15:0] COEF_X_RST       = 16'd485;
  localparam logic [15:0] COEF_Y_RST       = 16'd500;
  localparam logic [15:0] COEF_YAW_RST     = 16'd8977;
  localparam logic [14:0] YAW_GATE_RST     = 15'd32000;

  localparam logic [16:0] ATAN_TAB [CORDIC_STEPS] = '{
    17'd65536, 17'd38688, 17'd20442, 17'd10377, 17'd5208, 17'd2607, 17'd1304, 17'd652,
    17'd326,   17'd163,   17'd81,    17'd41,    17'd20,   17'd10,   17'd5,    17'd3
  };

  // round to nearest, halves away from zero
  function automatic logic signed [47:0] rnd_shift(input logic signed [47:0] p,
                                                   input int unsigned k);
    logic [47:0] m;
    logic [47:0] r;
    m = p[47] ? 48'(-p) : 48'(p);
    r = (m + (48'd1 << (k - 1))) >> k;
    return p[47] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    logic signed [15:0] res;
    if (v > 48'sd32767) begin
      res = 16'sh7fff;
    end else if (v < -48'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/mov_lane.sv =====
// One wheel lane: glitch rejection against the limit and the held last value.
// Uses mov_pkg.
`default_nettype none

module mov_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic signed [15:0] wheel,
  input  logic [14:0]        limit,
  output logic signed [15:0] used,
  output logic               flag
);
  import mov_pkg::*;

  logic signed [15:0] last_r;
  logic               flag_r;
  logic [16:0]        mag;
  logic               reject;

  always_comb begin
    mag    = wheel[15] ? 17'(-{wheel[15], wheel}) : {1'b0, wheel};
    reject = mag > {2'b00, limit};
  end

  // a rejected sample keeps the old value, which is also the value used
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      flag_r <= 1'b0;
    end else if (load) begin
      if (!reject) begin
        last_r <= wheel;
      end
      flag_r <= reject;
    end
  end

  assign used = last_r;
  assign flag = flag_r;

endmodule

`default_nettype wire

// ===== sv/mov_cordic.sv =====
// Heading to cosine/sine: wrap, quantize by a reciprocal multiply, then a
// 16-step CORDIC with quadrant folding. Uses mov_pkg.
`default_nettype none

module mov_cordic #(
  parameter int unsigned TrigBits = mov_pkg::TRIG_TABLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [15:0]                heading,
  output logic                              done,
  output logic signed [mov_pkg::TRIG_W-1:0] cos_q,
  output logic signed [mov_pkg::TRIG_W-1:0] sin_q
);
  import mov_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_MOD, ST_DIV, ST_QRND, ST_ROT, ST_DONE} state_t;

  state_t                    state_r;
  logic                      done_r;
  logic [16:0]               hr_r;
  logic [TrigBits-1:0]       q_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [TRIG_W-1:0]  x_r, y_r, ang_r, cos_r, sin_r;
  logic [1:0]                quad_r;

  logic [16:0]               hr_init;
  logic [29:0]               n_div;
  logic [20:0]               m_div;
  logic [41:0]               q_prod;
  logic [TURN_BITS-1:0]      z;
  logic signed [TRIG_W-1:0]  xs, ys, atan, x_nxt, y_nxt, ang_nxt;

  always_comb begin
    hr_init = 17'({heading[15], heading}) + HEADING_BIAS;
    // round(hr * 2^TrigBits / 23040): drop the power of two, then divide by 45
    n_div   = (30'(hr_r) << TrigBits) + 30'(HEADING_HALF);
    m_div   = n_div[29:TURN_POW2_SHIFT];
    q_prod  = m_div * RECIP_45;
    z       = {q_r, {(TURN_BITS - TrigBits){1'b0}}};
    xs      = x_r >>> cnt_r;
    ys      = y_r >>> cnt_r;
    atan    = $signed({{(TRIG_W - 17){1'b0}}, ATAN_TAB[cnt_r]});
    if (!ang_r[TRIG_W-1]) begin
      x_nxt   = x_r - ys;
      y_nxt   = y_r + xs;
      ang_nxt = ang_r - atan;
    end else begin
      x_nxt   = x_r + ys;
      y_nxt   = y_r - xs;
      ang_nxt = ang_r + atan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            hr_r    <= hr_init;
            done_r  <= 1'b0;
            state_r <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (hr_r >= HEADING_TURN) begin
            hr_r <= hr_r - HEADING_TURN;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          // a step count of a full turn wraps to zero
          q_r     <= q_prod[RECIP_SHIFT +: TrigBits];
          state_r <= ST_QRND;
        end
        ST_QRND: begin
          x_r     <= CORDIC_GAIN;
          y_r     <= '0;
          ang_r   <= $signed({{(TRIG_W - QUAD_BITS){1'b0}}, z[QUAD_BITS-1:0]});
          quad_r  <= z[TURN_BITS-1:QUAD_BITS];
          cnt_r   <= '0;
          state_r <= ST_ROT;
        end
        ST_ROT: begin
          x_r   <= x_nxt;
          y_r   <= y_nxt;
          ang_r <= ang_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          unique case (quad_r)
            2'd0: begin cos_r <= x_r;  sin_r <= y_r;  end
            2'd1: begin cos_r <= -y_r; sin_r <= x_r;  end
            2'd2: begin cos_r <= -x_r; sin_r <= -y_r; end
            default: begin cos_r <= y_r; sin_r <= -x_r; end
          endcase
          done_r  <= 1'b1;
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign cos_q = cos_r;
  assign sin_q = sin_r;

endmodule

`default_nettype wire

// ===== sv/mecanum_odometry_velocity_top.sv =====
// Top level of the mecanum odometry block: wheel lanes, body sums, CORDIC rotation.
// Uses mov_pkg, mov_lane, mov_cordic.
`default_nettype none

// Mecanum odometry. One word in gives one word out. From acceptance until its
// result is registered, an item passes through the heading wrap, one
// reciprocal multiply for the heading step, the 16 CORDIC iterations of the
// rotation unit and the products and rounding of S_MA, S_MB, S_MC and S_OUT;
// the next word can be accepted once the result is in the output register,
// even if not yet taken. A stalled output holds the block in its last step
// until the register frees.
// Configuration writes are always ready and must only happen while idle.

module mecanum_odometry_velocity_top #(
  parameter int unsigned TRIG_TABLE_BITS = mov_pkg::TRIG_TABLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [15:0]                   in_wheel_front_left,
  input  logic signed [15:0]                   in_wheel_front_right,
  input  logic signed [15:0]                   in_wheel_rear_left,
  input  logic signed [15:0]                   in_wheel_rear_right,
  input  logic signed [15:0]                   in_heading,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [15:0]                   out_body_vx,
  output logic signed [15:0]                   out_body_vy,
  output logic signed [15:0]                   out_yaw_rate,
  output logic signed [15:0]                   out_world_vx,
  output logic signed [15:0]                   out_world_vy,
  output logic [3:0]                           out_glitch_flags,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mov_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mov_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import mov_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SUM, S_ROUND, S_WAIT, S_MA, S_MB, S_MC, S_OUT} state_t;

  state_t state_r;

  logic [14:0] glitch_limit_r, yaw_gate_r;
  logic [15:0] coef_x_r, coef_y_r, coef_yaw_r;

  logic                accept;
  logic signed [15:0]  wheel_in [4];
  logic signed [15:0]  lane_w   [4];
  logic [3:0]          lane_flag;

  logic                      trig_done;
  logic signed [TRIG_W-1:0]  cos_q, sin_q;

  logic signed [18:0] sx, sy, sz;
  logic signed [16:0] cx, cy, cz;
  logic signed [35:0] p_x_r, p_y_r, p_z_r;
  logic signed [21:0] vx_r, vy_r;
  logic signed [20:0] yaw;
  logic [20:0]        yaw_mag;
  logic signed [15:0] last_yaw_r;
  logic signed [41:0] p1_r, p2_r;
  logic signed [15:0] wx_r, wy_r;
  logic signed [47:0] diff, summ;

  logic               out_valid_r;
  logic signed [15:0] o_bvx_r, o_bvy_r, o_yaw_r, o_wvx_r, o_wvy_r;
  logic [3:0]         o_flags_r;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glitch_limit_r <= GLITCH_LIMIT_RST;
      coef_x_r       <= COEF_X_RST;
      coef_y_r       <= COEF_Y_RST;
      coef_yaw_r     <= COEF_YAW_RST;
      yaw_gate_r     <= YAW_GATE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GLITCH_LIMIT: glitch_limit_r <= cfg_data[14:0];
        REG_COEF_X:       coef_x_r       <= cfg_data;
        REG_COEF_Y:       coef_y_r       <= cfg_data;
        REG_COEF_YAW:     coef_yaw_r     <= cfg_data;
        REG_YAW_GATE:     yaw_gate_r     <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  assign wheel_in[0] = in_wheel_front_left;
  assign wheel_in[1] = in_wheel_front_right;
  assign wheel_in[2] = in_wheel_rear_left;
  assign wheel_in[3] = in_wheel_rear_right;

  for (genvar g = 0; g < 4; g++) begin : g_lane
    mov_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .load  (accept),
      .wheel (wheel_in[g]),
      .limit (glitch_limit_r),
      .used  (lane_w[g]),
      .flag  (lane_flag[g])
    );
  end

  mov_cordic #(.TrigBits(TRIG_TABLE_BITS)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept),
    .heading (in_heading),
    .done    (trig_done),
    .cos_q   (cos_q),
    .sin_q   (sin_q)
  );

  // merge the lanes
  always_comb begin
    sx = 19'(lane_w[0]) - 19'(lane_w[1]) - 19'(lane_w[2]) + 19'(lane_w[3]);
    sy = 19'(lane_w[0]) + 19'(lane_w[1]) + 19'(lane_w[2]) + 19'(lane_w[3]);
    sz = 19'(lane_w[1]) - 19'(lane_w[0]) - 19'(lane_w[2]) + 19'(lane_w[3]);
    cx = $signed({1'b0, coef_x_r});
    cy = $signed({1'b0, coef_y_r});
    cz = $signed({1'b0, coef_yaw_r});
    yaw     = 21'(rnd_shift(48'(p_z_r), 14));
    yaw_mag = yaw[20] ? 21'(-yaw) : 21'(yaw);
    diff    = 48'(p1_r) - 48'(p2_r);
    summ    = 48'(p1_r) + 48'(p2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      last_yaw_r  <= '0;
    end else begin
      // a word loaded in S_OUT sets valid itself
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          p_x_r   <= cx * sx;
          p_y_r   <= cy * sy;
          p_z_r   <= cz * sz;
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          vx_r <= 22'(rnd_shift(48'(p_x_r), 12));
          vy_r <= 22'(rnd_shift(48'(p_y_r), 12));
          // keep the previous yaw when the new one reaches the gate
          if (yaw_mag < {6'd0, yaw_gate_r}) begin
            last_yaw_r <= 16'(yaw);
          end
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (trig_done) begin
            state_r <= S_MA;
          end
        end
        S_MA: begin
          p1_r    <= vx_r * cos_q;
          p2_r    <= vy_r * sin_q;
          state_r <= S_MB;
        end
        S_MB: begin
          wx_r    <= sat16(rnd_shift(diff, 16));
          p1_r    <= vx_r * sin_q;
          p2_r    <= vy_r * cos_q;
          state_r <= S_MC;
        end
        S_MC: begin
          wy_r    <= sat16(rnd_shift(summ, 16));
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            o_bvx_r     <= sat16(48'(vx_r));
            o_bvy_r     <= sat16(48'(vy_r));
            o_yaw_r     <= last_yaw_r;
            o_wvx_r     <= wx_r;
            o_wvy_r     <= wy_r;
            o_flags_r   <= lane_flag;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_body_vx      = o_bvx_r;
  assign out_body_vy      = o_bvy_r;
  assign out_yaw_rate     = o_yaw_r;
  assign out_world_vx     = o_wvx_r;
  assign out_world_vy     = o_wvy_r;
  assign out_glitch_flags = o_flags_r;

endmodule

`default_nettype wire

// ===== sv/mov_checker.sv =====
// Port-level checks for the mecanum odometry top, bound to it below.
// Uses mecanum_odometry_velocity_top_defines.svh.
`default_nettype none

`include "mecanum_odometry_velocity_top_defines.svh"

module mov_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_body_vx,
  input logic signed [15:0] out_body_vy,
  input logic signed [15:0] out_yaw_rate,
  input logic signed [15:0] out_world_vx,
  input logic signed [15:0] out_world_vy
);

  // busy with the accepted word
  `MOV_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "ready after accept")
  // zero body velocity rotates to zero
  `MOV_ASSERT_IMP(a_zero_rotation, clk, rst_n, out_valid && out_body_vx == 16'sd0 && out_body_vy == 16'sd0, out_world_vx == 16'sd0 && out_world_vy == 16'sd0, "nonzero world velocity")
  // gated yaw never reaches the rails
  `MOV_ASSERT_IMP(a_yaw_range, clk, rst_n, out_valid, out_yaw_rate != 16'sh7fff && out_yaw_rate != 16'sh8000, "yaw outside gate")
  // stalled word holds
  `MOV_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_world_vx) && $stable(out_world_vy), "output dropped")

endmodule

bind mecanum_odometry_velocity_top mov_checker u_mov_checker (.*);

`default_nettype wire
